// ===== src/fasta_protein_stream_parser_top_defines.svh =====
// assertion macros for the fasta protein stream parser
// used by fasta_protein_stream_parser_top, expects clk_i and rst_ni in scope
`ifndef FASTA_PROTEIN_STREAM_PARSER_TOP_DEFINES_SVH
`define FASTA_PROTEIN_STREAM_PARSER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// plain property checked on every clock edge out of reset
`define FPSP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fpsp assertion failed");

// condition in this cycle implies consequence in the next cycle
`define FPSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fpsp assertion failed");

`else

`define FPSP_ASSERT(label, prop)
`define FPSP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== src/fpsp_pkg.sv =====
// shared types, constants and residue lookup for the fasta protein stream parser
// no dependencies
`default_nettype none

package fpsp_pkg;

  localparam logic [7:0] HdrMark = 8'h3e;
  localparam logic [7:0] LineEnd = 8'h0a;
  localparam logic [7:0] GapCode = 8'd24;
  localparam logic [7:0] UnknownCode = 8'd25;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    KIND_LABEL   = 2'd0,
    KIND_RESIDUE = 2'd1,
    KIND_EOR     = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  value;
    logic [15:0] record_index;
    logic        run_last;
  } out_t;

  // one classified byte: a first result and an optional trailing end of record
  typedef struct packed {
    logic        two;
    kind_e       kind;
    logic [7:0]  value;
    logic [15:0] index0;
    logic [15:0] index1;
  } op_t;

  function automatic logic [7:0] residue_of(input logic [7:0] b);
    logic [7:0] u;
    logic [7:0] r;
    u = ((b >= 8'h61) && (b <= 8'h7a)) ? (b - 8'h20) : b;
    unique case (u)
      8'h2d:   r = GapCode;
      8'h3f:   r = UnknownCode;
      8'h41:   r = 8'd1;
      8'h42:   r = 8'd21;
      8'h43:   r = 8'd5;
      8'h44:   r = 8'd4;
      8'h45:   r = 8'd7;
      8'h46:   r = 8'd14;
      8'h47:   r = 8'd8;
      8'h48:   r = 8'd9;
      8'h49:   r = 8'd10;
      8'h4b:   r = 8'd12;
      8'h4c:   r = 8'd11;
      8'h4d:   r = 8'd13;
      8'h4e:   r = 8'd3;
      8'h50:   r = 8'd15;
      8'h51:   r = 8'd6;
      8'h52:   r = 8'd2;
      8'h53:   r = 8'd16;
      8'h54:   r = 8'd17;
      8'h56:   r = 8'd20;
      8'h57:   r = 8'd18;
      8'h58:   r = 8'd23;
      8'h59:   r = 8'd19;
      8'h5a:   r = 8'd22;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/fasta_protein_stream_parser_top.sv =====
// FASTA protein stream parser. Takes one byte per cycle whenever full is low
// and gives label bytes, residue codes (1..25) and end of record marks, each
// tagged with its record index. A result is written into the queue and then
// loaded into the output register before it shows on the result port. A byte
// that closes two things at once (end of input flagged on a label or residue
// byte, or on a '>' in a sequence) gives two results and fills the single
// output register twice; the two-entry queue between the classifier and the
// output stage absorbs that, and full holds off new bytes while the queue is
// full; at most one result per cycle is drained. RECORD_INDEX_BITS sets where
// the record index saturates (at most 0xffff). Depends on fpsp_pkg,
// fpsp_front, fpsp_queue, fpsp_back and the defines header.
`default_nettype none
`include "fasta_protein_stream_parser_top_defines.svh"

module fasta_protein_stream_parser_top import fpsp_pkg::*; #(
  parameter int unsigned RECORD_INDEX_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push,
  output logic      full,
  input  wire in_t  in_item_i,
  output logic      empty,
  input  wire logic pop,
  output out_t      result_o
);

  localparam logic [15:0] IndexLimit = (RECORD_INDEX_BITS >= 16) ? 16'hffff :
    16'((33'd1 << RECORD_INDEX_BITS) - 33'd1);

  logic accept;
  logic q_wr, q_rd, q_nonempty, q_full;
  op_t  q_wr_data, q_head;

  assign accept = push & ~q_full;
  assign full   = q_full;

  fpsp_front #(
    .RecordIndexBits(RECORD_INDEX_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .wr_en_o  (q_wr),
    .wr_data_o(q_wr_data)
  );

  fpsp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (q_wr),
    .wr_data_i (q_wr_data),
    .rd_en_i   (q_rd),
    .rd_data_o (q_head),
    .nonempty_o(q_nonempty),
    .full_o    (q_full)
  );

  fpsp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .nonempty_i(q_nonempty),
    .head_i    (q_head),
    .rd_en_o   (q_rd),
    .pop_i     (pop),
    .empty_o   (empty),
    .result_o  (result_o)
  );

  // a beat that is not last for its byte is followed at once by its end of record
  `FPSP_ASSERT_NEXT(a_second_follows, !empty && pop && !result_o.run_last,
                    !empty && result_o.kind == KIND_EOR)
  `FPSP_ASSERT(a_index_saturates, empty || result_o.record_index <= IndexLimit)
  `FPSP_ASSERT(a_no_overflow, !(q_wr && q_full))
  `FPSP_ASSERT(a_eor_value_zero, empty || result_o.kind != KIND_EOR || result_o.value == 8'd0)

endmodule

`default_nettype wire

// ===== src/fpsp_front.sv =====
// front end: accepts bytes, tracks parse mode and record count, classifies
// each byte and queues those that give a result; depends on fpsp_pkg
`default_nettype none

module fpsp_front import fpsp_pkg::*; #(
  parameter int unsigned RecordIndexBits = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic accept_i,
  input  wire in_t  item_i,
  output logic      wr_en_o,
  output op_t       wr_data_o
);

  localparam logic [15:0] IndexLimit = (RecordIndexBits >= 16) ? 16'hffff :
    16'((33'd1 << RecordIndexBits) - 33'd1);

  typedef enum logic [1:0] {
    MODE_PRE   = 2'd0,
    MODE_LABEL = 2'd1,
    MODE_SEQ   = 2'd2
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  res;
  logic        one;
  op_t         op;

  always_comb begin
    res     = residue_of(item_i.data_byte);
    mode_d  = mode_q;
    count_d = count_q;
    one     = 1'b0;
    op      = '{two: 1'b0, kind: KIND_LABEL, value: item_i.data_byte,
                index0: count_q, index1: count_q};
    unique case (mode_q)
      MODE_LABEL: begin
        if (item_i.data_byte == LineEnd) begin
          mode_d = MODE_SEQ;
        end else begin
          one = 1'b1;
        end
      end
      MODE_SEQ: begin
        if (item_i.data_byte == HdrMark) begin
          one      = 1'b1;
          op.kind  = KIND_EOR;
          op.value = 8'd0;
          if (count_q < IndexLimit) begin
            count_d = count_q + 16'd1;
          end
          mode_d = MODE_LABEL;
        end else if (res != 8'd0) begin
          one      = 1'b1;
          op.kind  = KIND_RESIDUE;
          op.value = res;
        end
      end
      default: begin
        if (item_i.data_byte == HdrMark) begin
          mode_d = MODE_LABEL;
        end
      end
    endcase
    // end of stream closes an open record
    if (item_i.end_of_input) begin
      if (mode_d == MODE_LABEL || mode_d == MODE_SEQ) begin
        if (one) begin
          op.two    = 1'b1;
          op.index1 = count_d;
        end else begin
          one       = 1'b1;
          op.kind   = KIND_EOR;
          op.value  = 8'd0;
          op.index0 = count_d;
        end
      end
      mode_d  = MODE_PRE;
      count_d = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_PRE;
      count_q <= 16'd0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      count_q <= count_d;
    end
  end

  assign wr_en_o   = accept_i & one;
  assign wr_data_o = op;

endmodule

`default_nettype wire

// ===== src/fpsp_queue.sv =====
// short queue of classified bytes between front and back
// depends on fpsp_pkg
`default_nettype none

module fpsp_queue import fpsp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_en_i,
  input  wire op_t  wr_data_i,
  input  wire logic rd_en_i,
  output op_t       rd_data_o,
  output logic      nonempty_o,
  output logic      full_o
);

  localparam int unsigned PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntBits = $clog2(QueueDepth + 1);
  localparam logic [CntBits-1:0] CntFull = CntBits'(QueueDepth);
  localparam logic [PtrBits-1:0] PtrLast = PtrBits'(QueueDepth - 1);

  op_t                 mem_q [QueueDepth];
  logic [PtrBits-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0]  cnt_q;
  logic                do_wr, do_rd;

  assign do_wr = wr_en_i & (cnt_q != CntFull);
  assign do_rd = rd_en_i & (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign rd_data_o  = mem_q[rd_ptr_q];
  assign nonempty_o = (cnt_q != '0);
  assign full_o     = (cnt_q == CntFull);

endmodule

`default_nettype wire

// ===== src/fpsp_back.sv =====
// back end: expands queue entries into one or two results and holds the
// current result in an output register; depends on fpsp_pkg
`default_nettype none

module fpsp_back import fpsp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic nonempty_i,
  input  wire op_t  head_i,
  output logic      rd_en_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output out_t      result_o
);

  out_t res_q;
  logic valid_q;
  logic second_q;
  logic load;
  logic take_first_two;

  // output register frees up when empty or popped this beat
  assign load           = nonempty_i & (~valid_q | pop_i);
  assign take_first_two = ~second_q & head_i.two;
  assign rd_en_o        = load & ~take_first_two;

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (second_q) begin
        res_q <= '{kind: KIND_EOR, value: 8'd0, record_index: head_i.index1,
                   run_last: 1'b1};
      end else begin
        res_q <= '{kind: head_i.kind, value: head_i.value,
                   record_index: head_i.index0, run_last: ~head_i.two};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q  <= 1'b1;
        second_q <= take_first_two;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign empty_o  = ~valid_q;
  assign result_o = res_q;

endmodule

`default_nettype wire
